@@ rtl/core/dual_stepper_step_generator_odometry_defines.svh @@
// Assertion macros shared by the step generator RTL.
`ifndef DUAL_STEPPER_STEP_GENERATOR_ODOMETRY_DEFINES_SVH
`define DUAL_STEPPER_STEP_GENERATOR_ODOMETRY_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DSSGO_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DSSGO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/dssgo_pkg.sv @@
// Types and constants shared by the step generator modules.
`timescale 1ns / 1ps
package dssgo_pkg;

    localparam int NUM_W        = 16;
    localparam int DB_W         = 11;
    localparam int UNIT_W       = 8;
    localparam int DIST_W       = 32;
    localparam int HEAD_W       = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int SLOPE_OFFSET = 9;

    localparam logic [DB_W-1:0]   DEADBAND_RST = 11'd1;
    localparam logic [NUM_W-1:0]  SLOPE_RST    = 16'd11000;
    localparam logic [UNIT_W-1:0] COUNTS_RST   = 8'd21;
    localparam logic [UNIT_W-1:0] WIDTH_RST    = 8'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEADBAND = 2'd0,
        REG_SLOPE    = 2'd1,
        REG_COUNTS   = 2'd2,
        REG_WIDTH    = 2'd3
    } cfg_reg_t;

    // What one lane reports for the item it finished.
    typedef struct packed {
        logic              level;
        logic              neg;
        logic              moving;
        logic [DIST_W-1:0] steps;
    } lane_res_t;

endpackage

@@ rtl/core/dssgo_lane.sv @@
// One wheel lane: serial speed-to-period divider, period scaling and pulse phase.
`timescale 1ns / 1ps
`include "dual_stepper_step_generator_odometry_defines.svh"
module dssgo_lane #(
    parameter int SPEED_BITS = 12,
    parameter int PHASE_BITS = 24
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic                                 en,
    input  logic signed [SPEED_BITS-1:0]         speed,
    input  logic [dssgo_pkg::DB_W-1:0]           deadband,
    input  logic [dssgo_pkg::NUM_W-1:0]          slope,
    input  logic [dssgo_pkg::UNIT_W-1:0]         counts,
    input  logic [dssgo_pkg::UNIT_W-1:0]         width,
    input  logic                                 commit,
    output logic                                 done,
    output dssgo_pkg::lane_res_t                 res
);
    import dssgo_pkg::*;

    localparam int DIV_W     = SPEED_BITS + 1;
    localparam int REM_W     = DIV_W + 1;
    localparam int MAG_CMP_W = (SPEED_BITS > DB_W) ? SPEED_BITS : DB_W;
    localparam int CNT_W     = $clog2(NUM_W);
    localparam int PROD_W    = NUM_W + UNIT_W;
    localparam int HIGH_W    = 2 * UNIT_W;
    localparam int CMP_W     = (PHASE_BITS > PROD_W) ? PHASE_BITS : PROD_W;
    localparam logic [CMP_W-1:0] PMAX = CMP_W'((64'd1 << PHASE_BITS) - 64'd1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [PHASE_BITS-1:0]   phase_reg, phase_next;
    logic [DIST_W-1:0]       steps_reg, steps_next;

    logic                    en_reg, neg_reg, run_reg;
    logic [DIV_W-1:0]        div_reg;
    logic [REM_W-1:0]        rem_reg;
    logic [NUM_W-1:0]        num_reg;
    logic [PHASE_BITS-1:0]   period_reg, high_reg;

    logic [SPEED_BITS-1:0]   speed_u, mag;
    logic                    neg_in, run_in;
    logic [REM_W-1:0]        rem_shift, rem_diff;
    logic                    rem_ge;
    logic [UNIT_W:0]         width_p1;
    logic [NUM_W-1:0]        units;
    logic [PROD_W-1:0]       period_prod;
    logic [HIGH_W-1:0]       high_prod;
    logic [CMP_W-1:0]        period_ext, high_ext;
    logic                    active, step_now, level;
    logic [PHASE_BITS:0]     phase_inc;
    logic [DIST_W-1:0]       steps_upd;
    logic [PHASE_BITS-1:0]   phase_upd;

    // Magnitude, direction and deadband test of the incoming speed
    assign speed_u = speed;
    assign neg_in  = speed_u[SPEED_BITS-1];
    assign mag     = neg_in ? (~speed_u + 1'b1) : speed_u;
    assign run_in  = MAG_CMP_W'(mag) > MAG_CMP_W'(deadband);

    // One restoring division step per cycle; quotient bits shift into num_reg
    assign rem_shift = {rem_reg[REM_W-2:0], num_reg[NUM_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, div_reg};
    assign rem_diff  = rem_shift - {1'b0, div_reg};

    // Clamp to the minimum period, scale to ticks, saturate to the phase range
    assign width_p1    = {1'b0, width} + 1'b1;
    assign units       = (num_reg >= NUM_W'(width_p1)) ? num_reg : NUM_W'(width_p1);
    assign period_prod = PROD_W'(units) * PROD_W'(counts);
    assign high_prod   = HIGH_W'(width) * HIGH_W'(counts);
    assign period_ext  = CMP_W'(period_prod);
    assign high_ext    = CMP_W'(high_prod);

    // Pulse phase for the finished item
    assign active    = en_reg && run_reg && (period_reg != '0);
    assign step_now  = active && (phase_reg == '0);
    assign level     = active && (phase_reg < high_reg);
    assign phase_inc = {1'b0, phase_reg} + 1'b1;
    assign phase_upd = (!active || (phase_inc >= {1'b0, period_reg})) ? '0
                     : phase_inc[PHASE_BITS-1:0];

    always_comb
    begin
        if (!en_reg)
        begin
            steps_upd = '0;
        end
        else if (step_now)
        begin
            steps_upd = neg_reg ? (steps_reg - 1'b1) : (steps_reg + 1'b1);
        end
        else
        begin
            steps_upd = steps_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        steps_next = steps_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DIV;
                    cnt_next   = '0;
                end
            end
            S_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                    phase_next = phase_upd;
                    steps_next = steps_upd;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            phase_reg <= '0;
            steps_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
            steps_reg <= steps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && (state_reg == S_IDLE))
        begin
            en_reg  <= en;
            neg_reg <= neg_in;
            run_reg <= run_in;
            div_reg <= DIV_W'(mag) + DIV_W'(SLOPE_OFFSET);
            rem_reg <= '0;
            num_reg <= slope;
        end
        else if (state_reg == S_DIV)
        begin
            rem_reg <= rem_ge ? rem_diff : rem_shift;
            num_reg <= {num_reg[NUM_W-2:0], rem_ge};
        end
        if (state_reg == S_MUL)
        begin
            period_reg <= PHASE_BITS'((period_ext > PMAX) ? PMAX : period_ext);
            high_reg   <= PHASE_BITS'((high_ext > PMAX) ? PMAX : high_ext);
        end
    end

    assign done       = (state_reg == S_DONE);
    assign res.level  = level;
    assign res.neg    = neg_reg;
    assign res.moving = en_reg && run_reg;
    assign res.steps  = steps_upd;

    `DSSGO_ASSERT_NOW(a_start_idle, clk, rst_n, start, state_reg == S_IDLE, "lane started while busy")
    `DSSGO_ASSERT_NOW(a_commit_done, clk, rst_n, commit, state_reg == S_DONE, "lane committed before done")
    `DSSGO_ASSERT_NEXT(a_stop_clear, clk, rst_n, commit && !run_reg, phase_reg == '0, "stopped lane kept phase")

endmodule

@@ rtl/core/dssgo_merge.sv @@
// Merge stage: combines both lanes into the registered result item.
`timescale 1ns / 1ps
module dssgo_merge (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 commit,
    input  logic                                 out_stall,
    input  dssgo_pkg::lane_res_t                 lane_l,
    input  dssgo_pkg::lane_res_t                 lane_r,
    output logic                                 out_free,
    output logic                                 out_valid,
    output logic                                 step_left,
    output logic                                 dir_left,
    output logic                                 step_right,
    output logic                                 dir_right,
    output logic                                 driver_on,
    output logic signed [dssgo_pkg::DIST_W-1:0]  distance_left,
    output logic signed [dssgo_pkg::DIST_W-1:0]  distance_right,
    output logic signed [dssgo_pkg::DIST_W-1:0]  distance_average,
    output logic signed [dssgo_pkg::HEAD_W-1:0]  heading
);
    import dssgo_pkg::*;

    logic                out_valid_reg, out_valid_next;
    logic                step_l_reg, dir_l_reg, step_r_reg, dir_r_reg, drv_reg;
    logic [DIST_W-1:0]   dist_l_reg, dist_r_reg, avg_reg;
    logic [HEAD_W-1:0]   head_reg;
    logic [DIST_W:0]     sum;

    assign sum = {lane_l.steps[DIST_W-1], lane_l.steps}
               + {lane_r.steps[DIST_W-1], lane_r.steps};

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            step_l_reg <= lane_l.level;
            dir_l_reg  <= lane_l.neg;
            step_r_reg <= lane_r.level;
            dir_r_reg  <= !lane_r.neg;
            drv_reg    <= lane_l.moving || lane_r.moving;
            dist_l_reg <= lane_l.steps;
            dist_r_reg <= lane_r.steps;
            avg_reg    <= sum[DIST_W:1];
            head_reg   <= lane_r.steps[HEAD_W-1:0] - lane_l.steps[HEAD_W-1:0];
        end
    end

    assign out_valid        = out_valid_reg;
    assign step_left        = step_l_reg;
    assign dir_left         = dir_l_reg;
    assign step_right       = step_r_reg;
    assign dir_right        = dir_r_reg;
    assign driver_on        = drv_reg;
    assign distance_left    = dist_l_reg;
    assign distance_right   = dist_r_reg;
    assign distance_average = avg_reg;
    assign heading          = head_reg;

endmodule

@@ rtl/core/dual_stepper_step_generator_odometry.sv @@
// Top level of the dual-lane stepper step generator with wheel odometry.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+------------------------------------------
//  in       | in_valid / in_stall  | enable, speed_left, speed_right
//  out      | out_valid / out_stall| step/dir per lane, driver_on, distances,
//           |                      | distance_average, heading
//  cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item (timer tick) is taken at the acceptance edge, which loads both
// lanes. Each lane then runs the bit-serial restoring divider for the 16-bit
// quotient (one quotient bit per cycle), the period multiply and the commit
// into the result register. The next item can be taken the cycle after
// commit; in_stall is high from acceptance until commit.
// A result waiting in the output register does not block the next item; it
// only holds the commit of the following one until the result is taken.
// Reset clears the phases, the distances, the control state and loads the
// register defaults. cfg_ready is always high.
`timescale 1ns / 1ps
`include "dual_stepper_step_generator_odometry_defines.svh"
module dual_stepper_step_generator_odometry #(
    parameter int SPEED_BITS = 12,
    parameter int PHASE_BITS = 24
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic                                     enable,
    input  logic signed [SPEED_BITS-1:0]             speed_left,
    input  logic signed [SPEED_BITS-1:0]             speed_right,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic                                     step_left,
    output logic                                     dir_left,
    output logic                                     step_right,
    output logic                                     dir_right,
    output logic                                     driver_on,
    output logic signed [dssgo_pkg::DIST_W-1:0]      distance_left,
    output logic signed [dssgo_pkg::DIST_W-1:0]      distance_right,
    output logic signed [dssgo_pkg::DIST_W-1:0]      distance_average,
    output logic signed [dssgo_pkg::HEAD_W-1:0]      heading,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [dssgo_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [dssgo_pkg::CFG_DATA_W-1:0]         cfg_data
);
    import dssgo_pkg::*;

    // Configuration registers
    logic [DB_W-1:0]    deadband_reg, deadband_next;
    logic [NUM_W-1:0]   slope_reg, slope_next;
    logic [UNIT_W-1:0]  counts_reg, counts_next;
    logic [UNIT_W-1:0]  width_reg, width_next;

    // Item control: busy from acceptance until both lanes commit
    logic               busy_reg, busy_next;
    logic               accept, commit;
    logic               done_l, done_r, out_free;
    lane_res_t          res_l, res_r;

    assign cfg_ready = 1'b1;
    assign in_stall  = busy_reg;
    assign accept    = in_valid && !busy_reg;
    // Commit only when both lanes finished and the output register can take it
    assign commit    = busy_reg && done_l && done_r && out_free;

    always_comb
    begin
        deadband_next = deadband_reg;
        slope_next    = slope_reg;
        counts_next   = counts_reg;
        width_next    = width_reg;
        if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_DEADBAND: deadband_next = cfg_data[DB_W-1:0];
                REG_SLOPE:    slope_next    = cfg_data[NUM_W-1:0];
                REG_COUNTS:   counts_next   = cfg_data[UNIT_W-1:0];
                REG_WIDTH:    width_next    = cfg_data[UNIT_W-1:0];
                default:      deadband_next = deadband_reg;
            endcase
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (commit)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadband_reg <= DEADBAND_RST;
            slope_reg    <= SLOPE_RST;
            counts_reg   <= COUNTS_RST;
            width_reg    <= WIDTH_RST;
            busy_reg     <= 1'b0;
        end
        else
        begin
            deadband_reg <= deadband_next;
            slope_reg    <= slope_next;
            counts_reg   <= counts_next;
            width_reg    <= width_next;
            busy_reg     <= busy_next;
        end
    end

    // Two identical lanes work on the two wheel speeds of the item
    dssgo_lane #(
        .SPEED_BITS (SPEED_BITS),
        .PHASE_BITS (PHASE_BITS)
    ) u_lane_l (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .en       (enable),
        .speed    (speed_left),
        .deadband (deadband_reg),
        .slope    (slope_reg),
        .counts   (counts_reg),
        .width    (width_reg),
        .commit   (commit),
        .done     (done_l),
        .res      (res_l)
    );

    dssgo_lane #(
        .SPEED_BITS (SPEED_BITS),
        .PHASE_BITS (PHASE_BITS)
    ) u_lane_r (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .en       (enable),
        .speed    (speed_right),
        .deadband (deadband_reg),
        .slope    (slope_reg),
        .counts   (counts_reg),
        .width    (width_reg),
        .commit   (commit),
        .done     (done_r),
        .res      (res_r)
    );

    // Combine lane results into the output item: driver flag, average, heading
    dssgo_merge u_merge (
        .clk              (clk),
        .rst_n            (rst_n),
        .commit           (commit),
        .out_stall        (out_stall),
        .lane_l           (res_l),
        .lane_r           (res_r),
        .out_free         (out_free),
        .out_valid        (out_valid),
        .step_left        (step_left),
        .dir_left         (dir_left),
        .step_right       (step_right),
        .dir_right        (dir_right),
        .driver_on        (driver_on),
        .distance_left    (distance_left),
        .distance_right   (distance_right),
        .distance_average (distance_average),
        .heading          (heading)
    );

    `DSSGO_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy_reg, "accepted item did not mark busy")
    `DSSGO_ASSERT_NEXT(a_commit_free, clk, rst_n, commit, !busy_reg, "busy held after commit")
    `DSSGO_ASSERT_NEXT(a_commit_out, clk, rst_n, commit, out_valid, "committed item not presented")

endmodule
